>>> rtl/core/imh_pkg.sv
// ============================================================================
// imh_pkg: shared types and constants of the indexed min-heap timer queue
// Transaction types, action codes, status codes and sizes.
// ============================================================================
`default_nettype none

package imh_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_SPACE  = 256;
    localparam int TIME_BITS = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ID_W      = $clog2(ID_SPACE);
    localparam int MAX_POPS  = 64;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_FIRE   = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  timer_id;
        logic [31:0] expire_time;
        logic [31:0] now;
    } imh_in_t;

    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_id;
        logic [1:0]  status;
        logic [31:0] next_wait;
        logic        queue_empty;
        logic [6:0]  entry_count;
        logic        last;
    } imh_out_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  timer_id;
        logic [31:0] expire_time;
        logic [31:0] now;
    } imh_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/imh_front.sv
// ============================================================================
// imh_front: command intake
// Accepts input transactions into a two-entry queue toward the heap engine.
// ============================================================================
`default_nettype none

module imh_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    output logic                   stall,
    input  imh_pkg::imh_in_t       data,
    output logic                   cmd_valid,
    input  wire logic              cmd_take,
    output imh_pkg::imh_cmd_t      cmd
);
    import imh_pkg::*;

    imh_cmd_t   q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       push;
    logic       pop;

    assign stall     = (cnt_reg == 2'd2);
    assign push      = valid && !stall;
    assign pop       = cmd_take && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[rd_reg ^ cnt_reg[0]].action      <= data.action;
            q_reg[rd_reg ^ cnt_reg[0]].timer_id    <= data.timer_id;
            q_reg[rd_reg ^ cnt_reg[0]].expire_time <= data.expire_time;
            q_reg[rd_reg ^ cnt_reg[0]].now         <= data.now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/imh_back.sv
// ============================================================================
// imh_back: heap engine
// Carries out commands on the heap memories one read or write step at a time.
// ============================================================================
`default_nettype none

module imh_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_take,
    input  imh_pkg::imh_cmd_t      cmd,
    output logic                   valid,
    input  wire logic              stall,
    output imh_pkg::imh_out_t      data
);
    import imh_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_LOOK  = 15'b000000000000010,
        S_LAST  = 15'b000000000000100,
        S_LASTD = 15'b000000000001000,
        S_DOWN  = 15'b000000000010000,
        S_DL    = 15'b000000000100000,
        S_DLD   = 15'b000000001000000,
        S_DRD   = 15'b000000010000000,
        S_DCMP  = 15'b000000100000000,
        S_UP    = 15'b000001000000000,
        S_UL    = 15'b000010000000000,
        S_UD    = 15'b000100000000000,
        S_WRITE = 15'b001000000000000,
        S_ROOT  = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } state_t;

    logic [ID_W-1:0]      ids_mem    [CAPACITY];
    logic [TIME_BITS-1:0] exp_mem    [CAPACITY];
    logic [SLOT_W-1:0]    slot_mem   [ID_SPACE];
    logic [ID_SPACE-1:0]  present_reg;

    state_t               state_reg;
    imh_cmd_t             cmd_reg;
    logic [CNT_W-1:0]     size_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [SLOT_W-1:0]    start_reg;
    logic [SLOT_W-1:0]    rd_addr_reg;
    logic [ID_W-1:0]      ent_id_reg;
    logic [TIME_BITS-1:0] ent_exp_reg;
    logic [ID_W-1:0]      c_id_reg;
    logic [TIME_BITS-1:0] c_exp_reg;
    logic [SLOT_W-1:0]    c_slot_reg;
    logic                 fired_reg;
    logic [ID_W-1:0]      fid_reg;
    logic [1:0]           status_reg;
    logic [6:0]           pops_reg;
    logic                 out_valid_reg;
    imh_out_t             out_reg;

    logic [SLOT_W-1:0]    rd_addr;
    logic [ID_W-1:0]      slot_addr;
    logic [ID_W-1:0]      rd_id_q;
    logic [TIME_BITS-1:0] rd_exp_q;
    logic [SLOT_W-1:0]    slot_q;
    logic                 we;
    logic [SLOT_W-1:0]    wa;
    logic [ID_W-1:0]      wid;
    logic [TIME_BITS-1:0] wex;
    logic [CNT_W:0]       child_w;
    logic [CNT_W:0]       right_w;
    logic [CNT_W:0]       size_w;
    logic [CNT_W-1:0]     size_m1;
    logic [SLOT_W-1:0]    parent_slot;
    logic                 out_free;
    logic                 pop_ok;
    logic                 skip_emit;
    logic                 emit_go;
    logic                 do_pop;
    logic [TIME_BITS-1:0] wait_w;

    assign out_free    = !out_valid_reg || !stall;
    assign valid       = out_valid_reg;
    assign data        = out_reg;
    assign cmd_take    = (state_reg == S_IDLE);
    assign child_w     = {1'b0, pos_reg, 1'b1};
    assign right_w     = child_w + (CNT_W + 1)'(1);
    assign size_w      = {1'b0, size_reg};
    assign size_m1     = size_reg - CNT_W'(1);
    assign parent_slot = (pos_reg - SLOT_W'(1)) >> 1;
    assign slot_addr   = cmd.timer_id[ID_W-1:0];
    assign rd_addr     = (state_reg == S_ROOT || state_reg == S_EMIT) ? '0 : rd_addr_reg;

    assign pop_ok    = (cmd_reg.action == ACT_TICK) && (size_reg != '0)
                       && (rd_exp_q <= cmd_reg.now[TIME_BITS-1:0])
                       && (pops_reg < 7'(MAX_POPS));
    assign skip_emit = (cmd_reg.action == ACT_TICK) && !fired_reg && pop_ok;
    assign emit_go   = (state_reg == S_EMIT) && out_free && !skip_emit;
    assign do_pop    = (state_reg == S_EMIT) && pop_ok && (skip_emit || out_free);
    assign wait_w    = (size_reg != '0 && rd_exp_q > cmd_reg.now[TIME_BITS-1:0])
                       ? rd_exp_q - cmd_reg.now[TIME_BITS-1:0] : '0;

    always_ff @(posedge clk)
    begin
        rd_id_q  <= ids_mem[rd_addr];
        rd_exp_q <= exp_mem[rd_addr];
        slot_q   <= slot_mem[slot_addr];
        if (we)
        begin
            ids_mem[wa]   <= wid;
            exp_mem[wa]   <= wex;
            slot_mem[wid] <= wa;
        end
    end

    always_comb
    begin
        we  = 1'b0;
        wa  = pos_reg;
        wid = ent_id_reg;
        wex = ent_exp_reg;
        if (state_reg == S_DCMP && !(ent_exp_reg < c_exp_reg))
        begin
            we  = 1'b1;
            wid = c_id_reg;
            wex = c_exp_reg;
        end
        else if (state_reg == S_UD && !(rd_exp_q < ent_exp_reg))
        begin
            we  = 1'b1;
            wid = rd_id_q;
            wex = rd_exp_q;
        end
        else if (state_reg == S_WRITE)
        begin
            we  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            size_reg    <= '0;
            present_reg <= '0;
            pos_reg     <= '0;
            start_reg   <= '0;
            rd_addr_reg <= '0;
            ent_id_reg  <= '0;
            ent_exp_reg <= '0;
            c_id_reg    <= '0;
            c_exp_reg   <= '0;
            c_slot_reg  <= '0;
            fired_reg   <= 1'b0;
            fid_reg     <= '0;
            status_reg  <= ST_OK;
            pops_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd;
                        fired_reg  <= 1'b0;
                        fid_reg    <= '0;
                        status_reg <= ST_OK;
                        pops_reg   <= '0;
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_ROOT;
                    case (cmd_reg.action) inside
                        ACT_ADD:
                        begin
                            ent_id_reg  <= cmd_reg.timer_id[ID_W-1:0];
                            ent_exp_reg <= cmd_reg.expire_time[TIME_BITS-1:0];
                            if (present_reg[cmd_reg.timer_id])
                            begin
                                pos_reg   <= slot_q;
                                start_reg <= slot_q;
                                state_reg <= S_DOWN;
                            end
                            else if (size_reg >= CNT_W'(CAPACITY))
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                present_reg[cmd_reg.timer_id] <= 1'b1;
                                pos_reg   <= size_reg[SLOT_W-1:0];
                                start_reg <= size_reg[SLOT_W-1:0];
                                size_reg  <= size_reg + CNT_W'(1);
                                state_reg <= S_UP;
                            end
                        end
                        ACT_REMOVE, ACT_FIRE:
                        begin
                            if (!present_reg[cmd_reg.timer_id])
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                            else
                            begin
                                fired_reg   <= (cmd_reg.action == ACT_FIRE);
                                fid_reg     <= cmd_reg.timer_id[ID_W-1:0];
                                present_reg[cmd_reg.timer_id] <= 1'b0;
                                size_reg    <= size_m1;
                                pos_reg     <= slot_q;
                                start_reg   <= slot_q;
                                rd_addr_reg <= size_m1[SLOT_W-1:0];
                                if (slot_q != size_m1[SLOT_W-1:0])
                                begin
                                    state_reg <= S_LAST;
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            present_reg <= '0;
                            size_reg    <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_LAST:
                begin
                    state_reg <= S_LASTD;
                end
                S_LASTD:
                begin
                    ent_id_reg  <= rd_id_q;
                    ent_exp_reg <= rd_exp_q;
                    state_reg   <= S_DOWN;
                end
                S_DOWN:
                begin
                    if (child_w < size_w)
                    begin
                        rd_addr_reg <= child_w[SLOT_W-1:0];
                        state_reg   <= S_DL;
                    end
                    else if (pos_reg == start_reg)
                    begin
                        state_reg <= S_UP;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_DL:
                begin
                    if (right_w < size_w)
                    begin
                        rd_addr_reg <= right_w[SLOT_W-1:0];
                    end
                    state_reg <= S_DLD;
                end
                S_DLD:
                begin
                    c_id_reg   <= rd_id_q;
                    c_exp_reg  <= rd_exp_q;
                    c_slot_reg <= child_w[SLOT_W-1:0];
                    state_reg  <= (right_w < size_w) ? S_DRD : S_DCMP;
                end
                S_DRD:
                begin
                    if (rd_exp_q < c_exp_reg)
                    begin
                        c_id_reg   <= rd_id_q;
                        c_exp_reg  <= rd_exp_q;
                        c_slot_reg <= right_w[SLOT_W-1:0];
                    end
                    state_reg <= S_DCMP;
                end
                S_DCMP:
                begin
                    if (ent_exp_reg < c_exp_reg)
                    begin
                        state_reg <= (pos_reg == start_reg) ? S_UP : S_WRITE;
                    end
                    else
                    begin
                        pos_reg   <= c_slot_reg;
                        state_reg <= S_DOWN;
                    end
                end
                S_UP:
                begin
                    if (pos_reg == '0)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        rd_addr_reg <= parent_slot;
                        state_reg   <= S_UL;
                    end
                end
                S_UL:
                begin
                    state_reg <= S_UD;
                end
                S_UD:
                begin
                    if (rd_exp_q < ent_exp_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        pos_reg   <= parent_slot;
                        state_reg <= S_UP;
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (do_pop)
                    begin
                        fired_reg   <= 1'b1;
                        fid_reg     <= rd_id_q;
                        pops_reg    <= pops_reg + 7'd1;
                        present_reg[rd_id_q] <= 1'b0;
                        size_reg    <= size_m1;
                        pos_reg     <= '0;
                        start_reg   <= '0;
                        rd_addr_reg <= size_m1[SLOT_W-1:0];
                        state_reg   <= (size_reg == CNT_W'(1)) ? S_ROOT : S_LAST;
                    end
                    else if (emit_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (emit_go)
        begin
            out_valid_reg       <= 1'b1;
            out_reg.fired       <= fired_reg;
            out_reg.fired_id    <= fired_reg ? fid_reg : '0;
            out_reg.status      <= status_reg;
            out_reg.next_wait   <= wait_w;
            out_reg.queue_empty <= (size_reg == '0);
            out_reg.entry_count <= size_reg;
            out_reg.last        <= !pop_ok;
        end
        else if (!stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/indexed_min_heap_timer_queue.sv
// ============================================================================
// indexed_min_heap_timer_queue: indexed binary min-heap of timers
// A command queue feeds a heap engine that keeps timers ordered by expiry.
// ============================================================================
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall, in_data
//  out     | output    | out_valid / out_stall, out_data
//
//  A simple action goes from the look-up state through the root read to its
//  result once an idle engine accepts it; an add or update also steps up past
//  each parent and down past each pair of children it is compared with, and a
//  removal first fetches the last entry through the single read port of the
//  heap memories. A tick pays a removal and a result per expired timer.
//  Reset clears the heap size and id flags at once; no clearing pass is run.
//  A stalled result holds while two further commands queue in the front.
`default_nettype none

module indexed_min_heap_timer_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  imh_pkg::imh_in_t   in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output imh_pkg::imh_out_t  out_data
);
    import imh_pkg::*;

    logic     cmd_valid;
    logic     cmd_take;
    imh_cmd_t cmd;

    imh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .data      (in_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    imh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

endmodule

`default_nettype wire

>>> bench/tb_indexed_min_heap_timer_queue.sv
// ============================================================================
// tb_indexed_min_heap_timer_queue: self-checking bench of the timer heap
// Drives add, update, remove, fire, tick and clear transactions, predicts
// every result with a behavioral heap model and compares each output
// transaction field by field, with random idling on both channels.
// ============================================================================
`default_nettype none

module tb_indexed_min_heap_timer_queue;

    import imh_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_PAUSE = 200;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    imh_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    imh_out_t out_data;

    indexed_min_heap_timer_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    logic [7:0]  heap_id_m  [CAPACITY];
    logic [31:0] heap_exp_m [CAPACITY];
    logic [5:0]  slot_m     [ID_SPACE];
    bit          present_m  [ID_SPACE];
    int unsigned size_m;

    imh_out_t    pending_results[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int unsigned cycles = 0;
    logic [31:0] clock_ms;

    function automatic void swap_slots(int a, int b);
        logic [7:0]  tid;
        logic [31:0] tex;
        tid = heap_id_m[a];
        tex = heap_exp_m[a];
        heap_id_m[a] = heap_id_m[b];
        heap_exp_m[a] = heap_exp_m[b];
        heap_id_m[b] = tid;
        heap_exp_m[b] = tex;
        slot_m[heap_id_m[a]] = a[5:0];
        slot_m[heap_id_m[b]] = b[5:0];
    endfunction

    function automatic void sift_up(int pos);
        int parent;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (heap_exp_m[parent] < heap_exp_m[pos])
                break;
            swap_slots(pos, parent);
            pos = parent;
        end
    endfunction

    function automatic bit sift_down(int start, int n);
        int pos;
        int child;
        pos = start;
        child = pos * 2 + 1;
        while (child < n)
        begin
            if (child + 1 < n && heap_exp_m[child + 1] < heap_exp_m[child])
                child++;
            if (heap_exp_m[pos] < heap_exp_m[child])
                break;
            swap_slots(pos, child);
            pos = child;
            child = pos * 2 + 1;
        end
        return pos > start;
    endfunction

    function automatic void delete_slot(int pos);
        int n;
        if (size_m == 0 || pos >= size_m)
            return;
        n = size_m - 1;
        if (pos < n)
            swap_slots(pos, n);
        present_m[heap_id_m[n]] = 1'b0;
        size_m = n;
        if (pos < n)
        begin
            if (!sift_down(pos, n))
                sift_up(pos);
        end
    endfunction

    function automatic void push_result(bit fired, logic [7:0] id, logic [1:0] status,
                                        logic [31:0] now, bit last);
        imh_out_t r;
        r = '0;
        r.fired = fired;
        r.fired_id = fired ? id : 8'd0;
        r.status = status;
        r.next_wait = (size_m > 0 && heap_exp_m[0] > now) ? heap_exp_m[0] - now : 32'd0;
        r.queue_empty = (size_m == 0);
        r.entry_count = size_m[6:0];
        r.last = last;
        pending_results = {pending_results, r};
    endfunction

    function automatic void predict_heap(imh_in_t t);
        int          pos;
        int          pops;
        logic [7:0]  fid;
        logic [1:0]  status;
        bit          fired;
        status = ST_OK;
        fired = 1'b0;
        case (t.action) inside
            ACT_ADD:
            begin
                if (present_m[t.timer_id])
                begin
                    pos = slot_m[t.timer_id];
                    heap_exp_m[pos] = t.expire_time;
                    if (!sift_down(pos, size_m))
                        sift_up(pos);
                end
                else if (size_m >= CAPACITY)
                    status = ST_FULL;
                else
                begin
                    pos = size_m;
                    heap_id_m[pos] = t.timer_id;
                    heap_exp_m[pos] = t.expire_time;
                    slot_m[t.timer_id] = pos[5:0];
                    present_m[t.timer_id] = 1'b1;
                    size_m = pos + 1;
                    sift_up(pos);
                end
            end
            ACT_REMOVE, ACT_FIRE:
            begin
                if (!present_m[t.timer_id])
                    status = ST_NOTFOUND;
                else
                begin
                    fired = (t.action == ACT_FIRE);
                    delete_slot(slot_m[t.timer_id]);
                end
            end
            ACT_TICK:
            begin
                pops = 0;
                while (size_m > 0 && heap_exp_m[0] <= t.now && pops < MAX_POPS)
                begin
                    fid = heap_id_m[0];
                    delete_slot(0);
                    pops++;
                    push_result(1'b1, fid, ST_OK, t.now,
                                !(size_m > 0 && heap_exp_m[0] <= t.now && pops < MAX_POPS));
                end
                if (pops == 0)
                    push_result(1'b0, 8'd0, ST_OK, t.now, 1'b1);
                return;
            end
            ACT_CLEAR:
            begin
                foreach (present_m[i])
                    present_m[i] = 1'b0;
                size_m = 0;
            end
            default:
            begin
            end
        endcase
        push_result(fired, t.timer_id, status, t.now, 1'b1);
    endfunction

    task automatic send_item(logic [2:0] action, logic [7:0] id, logic [31:0] expire,
                             logic [31:0] now);
        imh_in_t t;
        t.action = action;
        t.timer_id = id;
        t.expire_time = expire;
        t.now = now;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_heap(t);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        imh_out_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.fired !== want.fired)
                begin
                    $display("%0t: fired exp %0h got %0h", $time, want.fired, out_data.fired);
                    errors++;
                end
                if (out_data.fired_id !== want.fired_id)
                begin
                    $display("%0t: fired_id exp %0h got %0h", $time, want.fired_id,
                             out_data.fired_id);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status exp %0h got %0h", $time, want.status, out_data.status);
                    errors++;
                end
                if (out_data.next_wait !== want.next_wait)
                begin
                    $display("%0t: next_wait exp %0h got %0h", $time, want.next_wait,
                             out_data.next_wait);
                    errors++;
                end
                if (out_data.queue_empty !== want.queue_empty)
                begin
                    $display("%0t: queue_empty exp %0h got %0h", $time, want.queue_empty,
                             out_data.queue_empty);
                    errors++;
                end
                if (out_data.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count exp %0h got %0h", $time, want.entry_count,
                             out_data.entry_count);
                    errors++;
                end
                if (out_data.last !== want.last)
                begin
                    $display("%0t: last exp %0h got %0h", $time, want.last, out_data.last);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic test_directed();
        send_item(ACT_TICK, 8'd0, 32'd0, 32'd0);
        send_item(ACT_REMOVE, 8'd255, 32'd0, 32'd0);
        send_item(ACT_FIRE, 8'd0, 32'd0, 32'd0);
        send_item(ACT_ADD, 8'd255, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ADD, 8'd0, 32'd0, 32'd5);
        send_item(ACT_ADD, 8'd7, 32'd100, 32'd5);
        send_item(ACT_ADD, 8'd8, 32'd100, 32'd5);
        send_item(ACT_ADD, 8'd0, 32'd200, 32'd5);
        send_item(ACT_ADD, 8'd255, 32'd50, 32'hFFFF_FFFF);
        send_item(ACT_REMOVE, 8'd7, 32'hFFFF_FFFF, 32'd10);
        send_item(ACT_FIRE, 8'd8, 32'd0, 32'd10);
        send_item(ACT_FIRE, 8'd8, 32'd0, 32'd10);
        send_item(3'd5, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(3'd6, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(3'd7, 8'd1, 32'd1, 32'd1);
        send_item(ACT_TICK, 8'd0, 32'd0, 32'd49);
        send_item(ACT_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 8'd3, 32'd10, 32'd0);
        send_item(ACT_CLEAR, 8'd0, 32'd0, 32'd0);
        send_item(ACT_REMOVE, 8'd3, 32'd0, 32'd0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < CAPACITY; i++)
            send_item(ACT_ADD, 8'(i * 3 + 1), $urandom_range(0, 1000), 32'd0);
        send_item(ACT_ADD, 8'd2, 32'd5, 32'd0);
        send_item(ACT_ADD, 8'd4, 32'd7, 32'd0);
        send_item(ACT_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(ACT_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int count);
        int          sel;
        logic [7:0]  id;
        logic [31:0] expire;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
            expire = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : clock_ms + $urandom_range(0, 2000);
            if (sel < 45)
                send_item(ACT_ADD, id, expire, clock_ms);
            else if (sel < 57)
                send_item(ACT_REMOVE, id, $urandom, clock_ms);
            else if (sel < 69)
                send_item(ACT_FIRE, id, $urandom, clock_ms);
            else if (sel < 94)
            begin
                clock_ms = clock_ms + $urandom_range(0, 600);
                send_item(ACT_TICK, id, $urandom,
                          ($urandom_range(0, 19) == 0) ? $urandom : clock_ms);
            end
            else if (sel < 97)
                send_item(ACT_CLEAR, id, $urandom, clock_ms);
            else
                send_item(3'($urandom_range(5, 7)), id, $urandom, $urandom);
        end
    endtask

    initial
    begin
        size_m = 0;
        foreach (present_m[i])
            present_m[i] = 1'b0;
        clock_ms = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 76;
        test_directed();
        test_full_queue();
        test_random(37);
        wait_all_results();

        send_idle_pct = 76;
        recv_idle_pct = 17;
        test_random(37);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(37);

        wait_all_results();
        if (errors == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/imh_pkg.sv
rtl/core/imh_front.sv
rtl/core/imh_back.sv
rtl/core/indexed_min_heap_timer_queue.sv
bench/tb_indexed_min_heap_timer_queue.sv
